/* src/wtsp_pkg.sv */
// Shared constants and register codes for the world-to-screen projection block.
// No dependencies.
package wtsp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SIZE_W        = 16;
    localparam int Q_W           = 32;
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [2:0] {
        REG_ROW_X_FIRST   = 3'd0,
        REG_ROW_X_SECOND  = 3'd1,
        REG_ROW_Y_FIRST   = 3'd2,
        REG_ROW_Y_SECOND  = 3'd3,
        REG_ROW_W_FIRST   = 3'd4,
        REG_ROW_W_SECOND  = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } reg_idx_t;

endpackage

/* src/wtsp_front.sv */
// Front end: matrix rows, visibility test and numerator build, three stages.
// Depends on wtsp_pkg.
module wtsp_front
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CW       = 67 - FRAC_BITS,
    localparam int NUM_W    = CW + 1 + SIZE_W + FRAC_BITS,
    localparam int ENT_W    = 2 * NUM_W + CW + 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [95:0]         in_data,
    input  logic [63:0]         rows [6],
    input  logic [SIZE_W-1:0]   screen_width,
    input  logic [SIZE_W-1:0]   screen_height,
    output logic                push,
    input  logic                full,
    output logic [ENT_W-1:0]    entry
);

    localparam logic signed [CW-1:0] THRESH = CW'(((1 << FRAC_BITS) + 9) / 10);

    logic signed [31:0]    pt [3];
    logic signed [31:0]    cf [9];
    logic signed [31:0]    ofs [3];
    logic signed [63:0]    p_next [9];
    logic signed [63:0]    p_reg [9];
    logic signed [CW-1:0]  c_next [3];
    logic signed [CW-1:0]  c_reg [3];
    logic                  s1_v_reg, s2_v_reg, s3_v_reg;
    logic                  fe;
    logic signed [CW:0]    numx, numy;
    logic [CW:0]           magx, magy;
    logic [ENT_W-1:0]      ent_next;
    logic [ENT_W-1:0]      ent_reg;

    assign pt[0] = $signed(in_data[31:0]);
    assign pt[1] = $signed(in_data[63:32]);
    assign pt[2] = $signed(in_data[95:64]);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            cf[3*r]     = $signed(rows[2*r][31:0]);
            cf[3*r + 1] = $signed(rows[2*r][63:32]);
            cf[3*r + 2] = $signed(rows[2*r + 1][31:0]);
            ofs[r]      = $signed(rows[2*r + 1][63:32]);
        end
        for (int j = 0; j < 9; j++)
        begin
            p_next[j] = pt[j % 3] * cf[j];
        end
        for (int r = 0; r < 3; r++)
        begin
            c_next[r] = CW'(p_reg[3*r] >>> FRAC_BITS) + CW'(p_reg[3*r + 1] >>> FRAC_BITS)
                      + CW'(p_reg[3*r + 2] >>> FRAC_BITS) + CW'(ofs[r]);
        end
    end

    // stage 3: numerators scaled by viewport size
    always_comb
    begin
        numx = (CW+1)'(c_reg[0]) + (CW+1)'(c_reg[2]);
        numy = (CW+1)'(c_reg[2]) - (CW+1)'(c_reg[1]);
        magx = numx[CW] ? (CW+1)'(-numx) : numx;
        magy = numy[CW] ? (CW+1)'(-numy) : numy;
        ent_next = {
            (c_reg[2] >= THRESH),
            numy[CW],
            numx[CW],
            {c_reg[2][CW-2:0], 1'b0},
            (NUM_W'(magy) * NUM_W'(screen_height)) << FRAC_BITS,
            (NUM_W'(magx) * NUM_W'(screen_width)) << FRAC_BITS
        };
    end

    assign fe       = !(s3_v_reg && full);
    assign in_ready = fe;
    assign push     = s3_v_reg && !full;
    assign entry    = ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            p_reg   <= p_next;
            c_reg   <= c_next;
            ent_reg <= ent_next;
        end
    end

endmodule

/* src/wtsp_fifo.sv */
// Small register queue between front and back end.
// Depends on wtsp_pkg.
module wtsp_fifo
    import wtsp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH,
    localparam int PW   = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CNTW-1:0]  cnt_reg;

    assign full  = (cnt_reg == CNTW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

/* src/wtsp_back.sv */
// Back end: pipelined restoring divide, one quotient bit per stage, then saturation.
// Depends on wtsp_pkg.
module wtsp_back
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CW       = 67 - FRAC_BITS,
    localparam int NUM_W    = CW + 1 + SIZE_W + FRAC_BITS,
    localparam int ENT_W    = 2 * NUM_W + CW + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic [ENT_W-1:0] entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,
    output logic             m_tuser
);

    logic [NUM_W-1:0] rx [Q_W+1];
    logic [NUM_W-1:0] ry [Q_W+1];
    logic [CW-1:0]    dd [Q_W+1];
    logic [Q_W-1:0]   qx [Q_W+1];
    logic [Q_W-1:0]   qy [Q_W+1];
    logic             ox [Q_W+1];
    logic             oy [Q_W+1];
    logic             sx [Q_W+1];
    logic             sy [Q_W+1];
    logic             vs [Q_W+1];
    logic             v_reg [Q_W+1];
    logic             be;
    logic             out_v_reg, out_vis_reg;
    logic [31:0]      out_px_reg, out_py_reg;

    function automatic logic [31:0] sat(input logic [Q_W-1:0] q, input logic ovf,
                                        input logic neg);
        logic [31:0] r;
        if (neg)
            r = (ovf || q[31]) ? 32'h8000_0000 : 32'(-q);
        else
            r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
        return r;
    endfunction

    assign be  = !out_v_reg || m_tready;
    assign pop = be && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (be)
            v_reg[0] <= !empty;
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            rx[0] <= entry[NUM_W-1:0];
            ry[0] <= entry[2*NUM_W-1:NUM_W];
            dd[0] <= entry[2*NUM_W+CW-1:2*NUM_W];
            sx[0] <= entry[2*NUM_W+CW];
            sy[0] <= entry[2*NUM_W+CW+1];
            vs[0] <= entry[2*NUM_W+CW+2];
            ox[0] <= (NUM_W'(entry[NUM_W-1:Q_W])
                      >= NUM_W'(entry[2*NUM_W+CW-1:2*NUM_W]));
            oy[0] <= (NUM_W'(entry[2*NUM_W-1:NUM_W+Q_W])
                      >= NUM_W'(entry[2*NUM_W+CW-1:2*NUM_W]));
            qx[0] <= '0;
            qy[0] <= '0;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_div
        localparam int SH = Q_W - k;
        logic bx, by;

        assign bx = ((rx[k-1] >> SH) >= NUM_W'(dd[k-1]));
        assign by = ((ry[k-1] >> SH) >= NUM_W'(dd[k-1]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (be)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                rx[k] <= bx ? rx[k-1] - (NUM_W'(dd[k-1]) << SH) : rx[k-1];
                ry[k] <= by ? ry[k-1] - (NUM_W'(dd[k-1]) << SH) : ry[k-1];
                qx[k] <= {qx[k-1][Q_W-2:0], bx};
                qy[k] <= {qy[k-1][Q_W-2:0], by};
                dd[k] <= dd[k-1];
                ox[k] <= ox[k-1];
                oy[k] <= oy[k-1];
                sx[k] <= sx[k-1];
                sy[k] <= sy[k-1];
                vs[k] <= vs[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (be)
            out_v_reg <= v_reg[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            out_vis_reg <= vs[Q_W];
            out_px_reg  <= vs[Q_W] ? sat(qx[Q_W], ox[Q_W], sx[Q_W]) : '0;
            out_py_reg  <= vs[Q_W] ? sat(qy[Q_W], oy[Q_W], sy[Q_W]) : '0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_py_reg, out_px_reg};
    assign m_tuser  = out_vis_reg;

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("hidden point with nonzero pixels");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        be && v_reg[Q_W] |=> m_tvalid)
        else $error("finished item lost before output");

endmodule

/* src/world_to_screen_projection.sv */
// Top level of the world-to-screen projection block: config registers and the
// front end, queue and divide back end. Depends on wtsp_pkg and all wtsp_ modules.
//
// One point is accepted per clock and one result leaves per clock in steady
// state while the output is not stalled. The path from input to output runs
// through 3 front-end stages, the queue and 34 back-end stages (the 32 quotient
// bits of the pipelined divider plus load and output registers). The 4-entry
// queue lets the front keep taking points while the output is stalled.
module world_to_screen_projection
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pixel_x, pixel_y
    output logic        m_tuser    // visible
);

    localparam int CW    = 67 - FRAC_BITS;
    localparam int NUM_W = CW + 1 + SIZE_W + FRAC_BITS;
    localparam int ENT_W = 2 * NUM_W + CW + 3;

    logic [63:0]       rows_reg [6];
    logic [SIZE_W-1:0] width_reg, height_reg;
    reg_idx_t          idx;
    logic              wr;
    logic              push, full, pop, empty;
    logic [ENT_W-1:0]  wdata, rdata;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                rows_reg[i] <= '0;
            width_reg  <= SIZE_W'(1920);
            height_reg <= SIZE_W'(1080);
        end
        else if (wr)
        begin
            case (idx)
                REG_ROW_X_FIRST:   rows_reg[0] <= pwdata;
                REG_ROW_X_SECOND:  rows_reg[1] <= pwdata;
                REG_ROW_Y_FIRST:   rows_reg[2] <= pwdata;
                REG_ROW_Y_SECOND:  rows_reg[3] <= pwdata;
                REG_ROW_W_FIRST:   rows_reg[4] <= pwdata;
                REG_ROW_W_SECOND:  rows_reg[5] <= pwdata;
                REG_SCREEN_WIDTH:  width_reg   <= pwdata[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: height_reg  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW_X_FIRST:   prdata = rows_reg[0];
            REG_ROW_X_SECOND:  prdata = rows_reg[1];
            REG_ROW_Y_FIRST:   prdata = rows_reg[2];
            REG_ROW_Y_SECOND:  prdata = rows_reg[3];
            REG_ROW_W_FIRST:   prdata = rows_reg[4];
            REG_ROW_W_SECOND:  prdata = rows_reg[5];
            REG_SCREEN_WIDTH:  prdata = 64'(width_reg);
            REG_SCREEN_HEIGHT: prdata = 64'(height_reg);
            default:           prdata = '0;
        endcase
    end

    wtsp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_data       (s_tdata),
        .rows          (rows_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .push          (push),
        .full          (full),
        .entry         (wdata)
    );

    wtsp_fifo #(.WIDTH(ENT_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (rdata)
    );

    wtsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .entry    (rdata),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for world_to_screen_projection: APB register setup,
// streamed points with random idling, and a fixed-point projection predictor.
// Depends on wtsp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import wtsp_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int N_PHASES   = 5;
    localparam int PER_PHASE  = 270;
    localparam int CYCLE_MAX  = 400000;
    localparam longint W_MIN  = ((longint'(1) << FRAC) + 9) / 10;

    typedef struct {
        logic        visible;
        logic [31:0] pixel_x;
        logic [31:0] pixel_y;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // point_x, point_y, point_z
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // pixel_x, pixel_y
    logic        m_tuser;   // visible

    logic [63:0] regs_shadow [8];
    logic [95:0] points_pending [$];
    pixel_t      pixels_expected [$];
    int          n_errors = 0;
    int          n_points = 0;
    int          n_pixels = 0;
    int          n_visible = 0;
    int          cycles = 0;

    world_to_screen_projection u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint clip_sum(logic [63:0] first, logic [63:0] second,
                                        longint px, longint py, longint pz);
        longint s;
        s = (px * longint'($signed(first[31:0]))) >>> FRAC;
        s += (py * longint'($signed(first[63:32]))) >>> FRAC;
        s += (pz * longint'($signed(second[31:0]))) >>> FRAC;
        s += longint'($signed(second[63:32]));
        return s;
    endfunction

    function automatic logic [31:0] to_pixel(longint num, longint w, logic [15:0] size);
        logic [127:0] mag;
        logic [127:0] q;
        bit           neg;
        neg = num < 0;
        mag = 128'(neg ? -num : num);
        q = ((mag * 128'(size)) << FRAC) / (128'(w) * 2);
        if (neg)
        begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return 32'(0 - q[31:0]);
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic pixel_t project_point(logic [95:0] d);
        pixel_t r;
        longint px, py, pz, cx, cy, cw;
        px = longint'($signed(d[31:0]));
        py = longint'($signed(d[63:32]));
        pz = longint'($signed(d[95:64]));
        cx = clip_sum(regs_shadow[REG_ROW_X_FIRST], regs_shadow[REG_ROW_X_SECOND], px, py, pz);
        cy = clip_sum(regs_shadow[REG_ROW_Y_FIRST], regs_shadow[REG_ROW_Y_SECOND], px, py, pz);
        cw = clip_sum(regs_shadow[REG_ROW_W_FIRST], regs_shadow[REG_ROW_W_SECOND], px, py, pz);
        if (cw < W_MIN)
        begin
            r.visible = 1'b0;
            r.pixel_x = '0;
            r.pixel_y = '0;
        end
        else
        begin
            r.visible = 1'b1;
            r.pixel_x = to_pixel(cx + cw, cw, regs_shadow[REG_SCREEN_WIDTH][15:0]);
            r.pixel_y = to_pixel(cw - cy, cw, regs_shadow[REG_SCREEN_HEIGHT][15:0]);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        n_errors++;
    endtask

    // sender side: idle rates shift with progress
    always @(posedge clk or negedge rst_n)
    begin
        int idle_pct;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            idle_pct = (n_points < 450) ? 9 : (n_points < 900) ? 49 : 0;
            if (s_tvalid && s_tready)
            begin
                pixels_expected.push_back(project_point(s_tdata));
                n_points++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (points_pending.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= points_pending.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver side: stall rates mirror the sender
    always @(posedge clk or negedge rst_n)
    begin
        int     stall_pct;
        pixel_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            stall_pct = (n_points < 450) ? 49 : (n_points < 900) ? 9 : 0;
            if (m_tvalid && m_tready)
            begin
                if (pixels_expected.size() == 0)
                    report_mismatch("unexpected item", m_tdata[31:0], 32'd0);
                else
                begin
                    want = pixels_expected.pop_front();
                    if (m_tuser !== want.visible)
                        report_mismatch("visible", 32'(m_tuser), 32'(want.visible));
                    if (m_tdata[31:0] !== want.pixel_x)
                        report_mismatch("pixel_x", m_tdata[31:0], want.pixel_x);
                    if (m_tdata[63:32] !== want.pixel_y)
                        report_mismatch("pixel_y", m_tdata[63:32], want.pixel_y);
                    n_visible += want.visible;
                end
                n_pixels++;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_MAX)
        begin
            $display("timeout with %0d items outstanding", pixels_expected.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx) << 3;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx >= REG_SCREEN_WIDTH)
            regs_shadow[idx] = {48'd0, val[15:0]};
        else
            regs_shadow[idx] = val;
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (points_pending.size() > 0 || s_tvalid || pixels_expected.size() > 0)
            @(negedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [31:0] q16(int whole);
        return 32'(whole) << FRAC;
    endfunction

    function automatic logic [31:0] rand_coef(int mode);
        case (mode)
            0: return 32'($urandom_range(0, 2 ** 18) - 2 ** 17);
            1: return $urandom();
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [95:0] rand_point(int phase);
        logic [31:0] x, y, z;
        if ($urandom_range(3) == 0)
            return {$urandom(), $urandom(), $urandom()};
        x = 32'($urandom_range(0, 2 ** 24) - 2 ** 23);
        y = 32'($urandom_range(0, 2 ** 24) - 2 ** 23);
        z = (phase == 0) ? 32'($urandom_range(4000, 2 ** 23)) :
                           32'($urandom_range(0, 2 ** 24) - 2 ** 23);
        return {z, y, x};
    endfunction

    task automatic setup_phase(int phase);
        int mode;
        reg_idx_t r;
        if (phase == 0)
        begin
            reg_write(REG_ROW_X_FIRST,  {32'd0, q16(1)});
            reg_write(REG_ROW_X_SECOND, 64'd0);
            reg_write(REG_ROW_Y_FIRST,  {q16(1), 32'd0});
            reg_write(REG_ROW_Y_SECOND, 64'd0);
            reg_write(REG_ROW_W_FIRST,  64'd0);
            reg_write(REG_ROW_W_SECOND, {32'd0, q16(1)});
            return;
        end
        mode = (phase == 1) ? 1 : (phase == 4) ? 2 : 0;
        for (int i = 0; i < 6; i++)
        begin
            r = reg_idx_t'(i);
            reg_write(r, {rand_coef(mode), rand_coef(mode)});
        end
        if (phase == 2 || phase == 3)
            reg_write(REG_ROW_W_SECOND, {q16($urandom_range(1, 40)), rand_coef(0)});
        case (phase)
            1: begin reg_write(REG_SCREEN_WIDTH, 64'd65535); reg_write(REG_SCREEN_HEIGHT, 64'd1); end
            2: begin reg_write(REG_SCREEN_WIDTH, 64'd1); reg_write(REG_SCREEN_HEIGHT, 64'd65535); end
            default:
            begin
                reg_write(REG_SCREEN_WIDTH,  64'($urandom_range(1, 65535)));
                reg_write(REG_SCREEN_HEIGHT, 64'($urandom_range(1, 65535)));
            end
        endcase
    endtask

    initial
    begin
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        regs_shadow = '{default: 64'd0};
        regs_shadow[REG_SCREEN_WIDTH]  = 64'd1920;
        regs_shadow[REG_SCREEN_HEIGHT] = 64'd1080;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: all-zero matrix, nothing visible
        points_pending.push_back({q16(5), q16(3), q16(2)});
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            setup_phase(ph);
            if (ph == 0)
            begin
                points_pending.push_back({q16(1), 32'd0, 32'd0});
                points_pending.push_back({32'd6553, 32'd0, 32'd0});   // w just under 0.1
                points_pending.push_back({32'd6554, 32'd0, 32'd0});   // w exactly at limit
                points_pending.push_back({32'd6554, 32'h7FFF_FFFF, 32'h8000_0000});
                points_pending.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
                points_pending.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
                points_pending.push_back({32'h8000_0000, q16(1), q16(1)});
                points_pending.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
                points_pending.push_back({q16(2), q16(2), q16(-2)});
                points_pending.push_back({q16(2), q16(-2), q16(2)});
                points_pending.push_back({q16(10), q16(3), q16(-7)});
                points_pending.push_back(96'd0);
            end
            for (int i = 0; i < PER_PHASE; i++)
                points_pending.push_back(rand_point(ph));
            if (ph == 2)
            begin
                // hold new items back until the pipeline has drained
                wait_idle();
                for (int i = 0; i < 20; i++)
                    points_pending.push_back(rand_point(ph));
            end
            wait_idle();
        end

        repeat (60) @(posedge clk);
        $display("covered %0d points over %0d register settings, %0d visible",
                 n_points, N_PHASES + 1, n_visible);
        $display("%0d results checked, %0d mismatches", n_pixels, n_errors);
        if (n_errors == 0 && pixels_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* world_to_screen_projection.f */
src/wtsp_pkg.sv
src/wtsp_front.sv
src/wtsp_fifo.sv
src/wtsp_back.sv
src/world_to_screen_projection.sv
tb/tb_top.sv
